FILE: design/aqt_pkg.sv
package aqt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int OCC_W       = $clog2(TABLE_DEPTH + 1);

    localparam int PID_W   = 22;
    localparam int TOTAL_W = 32;
    localparam int SYM_W   = 16;
    localparam int SYM_N   = 4;
    localparam int TIME_W  = 64;

    localparam logic [TOTAL_W-1:0] THRESH_RESET = TOTAL_W'(10);

    typedef enum logic [1:0] {
        CMD_REPORT    = 2'd0,
        CMD_RELEASE   = 2'd1,
        CMD_KILL      = 2'd2,
        CMD_FALSE_POS = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_STOP = 2'd1,
        ACT_KILL = 2'd2,
        ACT_CONT = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOENTRY = 2'd1,
        ST_FULL    = 2'd2,
        ST_GONE    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MODE_STOPPED  = 2'd0,
        MODE_KILLED   = 2'd1,
        MODE_RELEASED = 2'd2
    } t_mode;

    typedef struct packed {
        logic [PID_W-1:0]              pid;
        logic [TOTAL_W-1:0]            total;
        logic [SYM_N-1:0][SYM_W-1:0]   pattern;
        logic [TIME_W-1:0]             stamp;
        t_mode                         mode;
        logic                          reviewed;
    } t_entry;

    typedef struct packed {
        logic load;
        logic scan;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
    } t_dp_stat;

    typedef struct packed {
        logic                          done;
        t_action                       action;
        t_status                       status;
        logic                          alert;
        logic [PID_W-1:0]              pid;
        logic [TOTAL_W-1:0]            total;
        logic [SYM_N-1:0][SYM_W-1:0]   pattern;
        logic [TIME_W-1:0]             stamp;
    } t_result;

endpackage

FILE: design/anomaly_quarantine_table_core.sv
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+---------------------------------
// command  | i_command .. i_task_alive               | taken when start high, busy low
// result   | o_action .. o_alert_time                | o_done high for one cycle
// config   | i_cfg_we, i_cfg_wdata (kill threshold)  | written when i_cfg_we is high
//
// Once accepted, the scan reads occupied entries in order until the pid is found (at most 64),
// or reads none when the table is empty. The update state then writes the entry where the command
// changes it and registers the result; the next item is taken at the edge ending the result cycle.
// The scan reads one entry per cycle from the single-port entry memory.
// Reset clears the occupancy and sets the threshold to 10; no clearing pass is needed.
// The result strobe cannot be stalled, and busy stays high until the result is issued.
module anomaly_quarantine_table_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [aqt_pkg::TOTAL_W-1:0]   i_cfg_wdata,
    input  logic [1:0]                    i_command,
    input  logic [aqt_pkg::PID_W-1:0]     i_pid,
    input  logic [aqt_pkg::TOTAL_W-1:0]   i_anomaly_count,
    input  logic [aqt_pkg::SYM_W-1:0]     i_ngram_0,
    input  logic [aqt_pkg::SYM_W-1:0]     i_ngram_1,
    input  logic [aqt_pkg::SYM_W-1:0]     i_ngram_2,
    input  logic [aqt_pkg::SYM_W-1:0]     i_ngram_3,
    input  logic [aqt_pkg::TIME_W-1:0]    i_now_ns,
    input  logic                          i_task_alive,
    output logic                          o_done,
    output logic [1:0]                    o_action,
    output logic [1:0]                    o_status,
    output logic                          o_alert,
    output logic [aqt_pkg::PID_W-1:0]     o_alert_pid,
    output logic [aqt_pkg::TOTAL_W-1:0]   o_alert_total,
    output logic [aqt_pkg::SYM_W-1:0]     o_alert_sym_0,
    output logic [aqt_pkg::SYM_W-1:0]     o_alert_sym_1,
    output logic [aqt_pkg::SYM_W-1:0]     o_alert_sym_2,
    output logic [aqt_pkg::SYM_W-1:0]     o_alert_sym_3,
    output logic [aqt_pkg::TIME_W-1:0]    o_alert_time
);

    aqt_pkg::t_dp_cmd  w_cmd;
    aqt_pkg::t_dp_stat w_stat;
    aqt_pkg::t_result  w_res;

    aqt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    aqt_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_command       (i_command),
        .i_pid           (i_pid),
        .i_anomaly_count (i_anomaly_count),
        .i_pattern       ({i_ngram_3, i_ngram_2, i_ngram_1, i_ngram_0}),
        .i_now_ns        (i_now_ns),
        .i_task_alive    (i_task_alive),
        .o_res           (w_res)
    );

    assign o_done        = w_res.done;
    assign o_action      = w_res.action;
    assign o_status      = w_res.status;
    assign o_alert       = w_res.alert;
    assign o_alert_pid   = w_res.pid;
    assign o_alert_total = w_res.total;
    assign o_alert_sym_0 = w_res.pattern[0];
    assign o_alert_sym_1 = w_res.pattern[1];
    assign o_alert_sym_2 = w_res.pattern[2];
    assign o_alert_sym_3 = w_res.pattern[3];
    assign o_alert_time  = w_res.stamp;

endmodule

FILE: design/aqt_ctrl.sv
module aqt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  aqt_pkg::t_dp_stat i_stat,
    output aqt_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_cmd.load   = i_start && (r_state == S_IDLE);
    assign o_cmd.scan   = (r_state == S_SCAN);
    assign o_cmd.update = (r_state == S_UPDATE);

endmodule

FILE: design/aqt_datapath.sv
module aqt_datapath (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  aqt_pkg::t_dp_cmd                             i_cmd,
    output aqt_pkg::t_dp_stat                            o_stat,
    input  logic                                         i_cfg_we,
    input  logic [aqt_pkg::TOTAL_W-1:0]                  i_cfg_wdata,
    input  logic [1:0]                                   i_command,
    input  logic [aqt_pkg::PID_W-1:0]                    i_pid,
    input  logic [aqt_pkg::TOTAL_W-1:0]                  i_anomaly_count,
    input  logic [aqt_pkg::SYM_N-1:0][aqt_pkg::SYM_W-1:0] i_pattern,
    input  logic [aqt_pkg::TIME_W-1:0]                   i_now_ns,
    input  logic                                         i_task_alive,
    output aqt_pkg::t_result                             o_res
);

    aqt_pkg::t_entry r_mem [aqt_pkg::TABLE_DEPTH];

    aqt_pkg::t_command                          r_cmd;
    logic [aqt_pkg::PID_W-1:0]                  r_pid;
    logic [aqt_pkg::TOTAL_W-1:0]                r_cnt;
    logic [aqt_pkg::SYM_N-1:0][aqt_pkg::SYM_W-1:0] r_pat;
    logic [aqt_pkg::TIME_W-1:0]                 r_now;
    logic                                       r_alive;
    logic [aqt_pkg::TOTAL_W-1:0]                r_thr;
    logic [aqt_pkg::OCC_W-1:0]                  r_occ;
    logic [aqt_pkg::OCC_W-1:0]                  r_addr;
    logic                                       r_rd_vld;
    logic [aqt_pkg::IDX_W-1:0]                  r_rd_idx;
    aqt_pkg::t_entry                            r_rd_data;
    logic                                       r_hit;
    logic [aqt_pkg::IDX_W-1:0]                  r_hit_idx;
    aqt_pkg::t_entry                            r_hit_data;
    aqt_pkg::t_result                           r_res;

    logic                                       w_match;
    logic                                       w_issue;
    logic [aqt_pkg::TOTAL_W:0]                  w_sum;
    logic [aqt_pkg::TOTAL_W-1:0]                w_sat;
    logic                                       n_we;
    logic                                       n_insert;
    logic [aqt_pkg::IDX_W-1:0]                  n_waddr;
    aqt_pkg::t_entry                            n_wdata;
    aqt_pkg::t_result                           n_res;

    assign w_match = r_rd_vld && !r_hit && (r_rd_data.pid == r_pid);
    assign w_issue = i_cmd.scan && !r_hit && !w_match && (r_addr < r_occ);
    assign o_stat.scan_done = r_hit || (!r_rd_vld && (r_addr >= r_occ));

    assign w_sum = {1'b0, r_hit_data.total} + {1'b0, r_cnt};
    assign w_sat = w_sum[aqt_pkg::TOTAL_W] ? '1 : w_sum[aqt_pkg::TOTAL_W-1:0];

    always_comb begin
        n_we     = 1'b0;
        n_insert = 1'b0;
        n_waddr  = r_hit_idx;
        n_wdata  = r_hit_data;
        n_res    = '0;
        n_res.done   = i_cmd.update;
        n_res.action = aqt_pkg::ACT_NONE;
        n_res.status = aqt_pkg::ST_OK;
        case (r_cmd)
            aqt_pkg::CMD_REPORT: begin
                if (!r_alive) begin
                    n_res.status = aqt_pkg::ST_GONE;
                end else if (r_hit) begin
                    n_we          = 1'b1;
                    n_wdata.total = w_sat;
                    n_res.alert   = 1'b1;
                    if ((r_hit_data.mode == aqt_pkg::MODE_STOPPED) && (w_sat >= r_thr)) begin
                        n_wdata.mode = aqt_pkg::MODE_KILLED;
                        n_res.action = aqt_pkg::ACT_KILL;
                    end else begin
                        n_res.action = aqt_pkg::ACT_STOP;
                    end
                end else if (r_occ >= aqt_pkg::OCC_W'(aqt_pkg::TABLE_DEPTH)) begin
                    n_res.status = aqt_pkg::ST_FULL;
                end else begin
                    n_we             = 1'b1;
                    n_insert         = 1'b1;
                    n_waddr          = r_occ[aqt_pkg::IDX_W-1:0];
                    n_wdata.pid      = r_pid;
                    n_wdata.total    = r_cnt;
                    n_wdata.pattern  = r_pat;
                    n_wdata.stamp    = r_now;
                    n_wdata.mode     = aqt_pkg::MODE_STOPPED;
                    n_wdata.reviewed = 1'b0;
                    n_res.alert      = 1'b1;
                    n_res.action     = aqt_pkg::ACT_STOP;
                end
            end
            aqt_pkg::CMD_RELEASE, aqt_pkg::CMD_KILL: begin
                if (r_hit && (r_hit_data.mode == aqt_pkg::MODE_STOPPED)) begin
                    n_we             = 1'b1;
                    n_wdata.reviewed = 1'b1;
                    n_wdata.mode     = (r_cmd == aqt_pkg::CMD_KILL) ?
                                       aqt_pkg::MODE_KILLED : aqt_pkg::MODE_RELEASED;
                    if (r_alive) begin
                        n_res.action = (r_cmd == aqt_pkg::CMD_KILL) ?
                                       aqt_pkg::ACT_KILL : aqt_pkg::ACT_CONT;
                    end else begin
                        n_res.status = aqt_pkg::ST_GONE;
                    end
                end else begin
                    n_res.status = aqt_pkg::ST_NOENTRY;
                end
            end
            aqt_pkg::CMD_FALSE_POS: begin
                if (!r_hit) begin
                    n_res.status = aqt_pkg::ST_NOENTRY;
                end else begin
                    n_we             = 1'b1;
                    n_wdata.reviewed = 1'b1;
                    if (r_hit_data.mode == aqt_pkg::MODE_STOPPED) begin
                        n_wdata.mode = aqt_pkg::MODE_RELEASED;
                        if (r_alive) begin
                            n_res.action = aqt_pkg::ACT_CONT;
                        end else begin
                            n_res.status = aqt_pkg::ST_GONE;
                        end
                    end else begin
                        n_res.status = aqt_pkg::ST_NOENTRY;
                    end
                end
            end
            default: begin
                n_res.status = aqt_pkg::ST_NOENTRY;
            end
        endcase
        if (n_res.alert) begin
            n_res.pid     = n_wdata.pid;
            n_res.total   = n_wdata.total;
            n_res.pattern = n_wdata.pattern;
            n_res.stamp   = n_wdata.stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= aqt_pkg::THRESH_RESET;
            r_occ    <= '0;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
            r_res    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_addr   <= '0;
                r_rd_vld <= 1'b0;
                r_hit    <= 1'b0;
            end else begin
                r_rd_vld <= w_issue;
                if (w_issue) begin
                    r_addr <= r_addr + aqt_pkg::OCC_W'(1);
                end
                if (w_match) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.update && n_insert) begin
                r_occ <= r_occ + aqt_pkg::OCC_W'(1);
            end
            if (i_cmd.update) begin
                r_res <= n_res;
            end else begin
                r_res <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= aqt_pkg::t_command'(i_command);
            r_pid   <= i_pid;
            r_cnt   <= i_anomaly_count;
            r_pat   <= i_pattern;
            r_now   <= i_now_ns;
            r_alive <= i_task_alive;
        end
        if (w_issue) begin
            r_rd_idx  <= r_addr[aqt_pkg::IDX_W-1:0];
            r_rd_data <= r_mem[r_addr[aqt_pkg::IDX_W-1:0]];
        end
        if (w_match) begin
            r_hit_idx  <= r_rd_idx;
            r_hit_data <= r_rd_data;
        end
        if (i_cmd.update && n_we) begin
            r_mem[n_waddr] <= n_wdata;
        end
    end

    assign o_res = r_res;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= aqt_pkg::OCC_W'(aqt_pkg::TABLE_DEPTH))
        else $error("occupancy exceeds table depth");

    a_occ_only_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.update |=> $stable(r_occ))
        else $error("occupancy changed outside an update");

    a_hit_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_hit) |-> $past(i_cmd.scan))
        else $error("hit latched outside a scan");

    a_alert_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res.alert |-> (r_res.done && (r_res.status == aqt_pkg::ST_OK)))
        else $error("alert without a successful result");

    a_result_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res.done |-> $past(i_cmd.update))
        else $error("result strobe without an update cycle");

endmodule
